// ----- sv/image_batch_session_deframer_assert.svh -----
// Assertion macros used by the checker file.
`ifndef IMAGE_BATCH_SESSION_DEFRAMER_ASSERT_SVH
`define IMAGE_BATCH_SESSION_DEFRAMER_ASSERT_SVH

// Concurrent check, clocked on the rising edge and held off during reset.
`define IBSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication check built on the one above.
`define IBSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `IBSD_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

// ----- sv/ibsd_pkg.sv -----
`default_nettype none
package ibsd_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 65536;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] IN_BYTES_RST = 17'd4096;
  localparam logic [31:0] OUT_BYTES_RST = 32'd24576;

  localparam int unsigned HDR_BYTES = 16;
  localparam logic [7:0] MARK_STOP = 8'h00;
  localparam logic [7:0] MARK_IMAGE = 8'h01;
  localparam logic [7:0] ERR_BAD_HEADER = 8'h00;
  localparam logic [7:0] ERR_BAD_MARKER = 8'h01;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_ACCEL_DONE = 2'd1;
  localparam logic [1:0] OP_XFER_DONE = 2'd2;

  localparam logic CFG_IN_BYTES = 1'b0;
  localparam logic CFG_OUT_BYTES = 1'b1;

  typedef enum logic [2:0] {
    KIND_STORE = 3'd0,
    KIND_RESP = 3'd1,
    KIND_START_ACCEL = 3'd2,
    KIND_START_XFER = 3'd3,
    KIND_ERROR = 3'd4
  } kind_e;

  typedef enum logic [6:0] {
    PH_PREFIX = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_MARKER = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_ACCEL = 7'b0010000,
    PH_XFER = 7'b0100000,
    PH_ERROR = 7'b1000000
  } phase_e;

  // Burst commands handed from the classifier to the sequencer
  typedef enum logic [2:0] {
    CMD_STORE = 3'd0,
    CMD_STORE_LAST = 3'd1,
    CMD_HDR_ACK = 3'd2,
    CMD_ACK = 3'd3,
    CMD_ERR = 3'd4,
    CMD_XFER = 3'd5
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic [15:0] addr;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h49;
      2'd1: b = 8'h4D;
      2'd2: b = 8'h47;
      default: b = 8'h33;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ack_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = 8'h41;
      2'd1: b = 8'h43;
      default: b = 8'h4B;
    endcase
    return b;
  endfunction

  // Index of the final result within a command's burst
  function automatic logic [2:0] cmd_last_idx(input cmd_e op);
    logic [2:0] n;
    unique case (op)
      CMD_STORE_LAST: n = 3'd1;
      CMD_HDR_ACK: n = 3'd6;
      CMD_ACK: n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ibsd_front.sv -----
`default_nettype none
module ibsd_front #(
  parameter int unsigned MAX_PAYLOAD_BYTES = ibsd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic [16:0]   in_bytes_i,
  output ibsd_pkg::cmd_t     push_cmd_o,
  output logic               push_o
);

  localparam int unsigned CW = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned LW = (CW > 17) ? CW : 17;

  ibsd_pkg::phase_e phase_q, phase_d;
  logic [1:0]  prefix_count_q, prefix_count_d;
  logic [3:0]  header_count_q, header_count_d;
  logic        magic_ok_q, magic_ok_d;
  logic [31:0] length_word_q, length_word_d;
  logic [CW-1:0] payload_count_q, payload_count_d;

  logic [CW-1:0] count_next;
  logic [LW-1:0] cfg_ext, max_ext, limit_raw, limit;
  logic          hdr_ok;

  always_comb begin
    cfg_ext = LW'(in_bytes_i);
    max_ext = LW'(MAX_PAYLOAD_BYTES);
    limit_raw = (cfg_ext > max_ext) ? max_ext : cfg_ext;
    limit = (limit_raw == '0) ? LW'(1) : limit_raw;
  end

  assign count_next = payload_count_q + CW'(1);
  assign hdr_ok = magic_ok_q && (length_word_q == 32'(in_bytes_i)) &&
                  (length_word_q != 32'd0) &&
                  (length_word_q <= 32'(MAX_PAYLOAD_BYTES));

  always_comb begin
    phase_d = phase_q;
    prefix_count_d = prefix_count_q;
    header_count_d = header_count_q;
    magic_ok_d = magic_ok_q;
    length_word_d = length_word_q;
    payload_count_d = payload_count_q;
    push_o = 1'b0;
    push_cmd_o.op = ibsd_pkg::CMD_STORE;
    push_cmd_o.addr = '0;
    push_cmd_o.data = '0;
    if (accept_i) begin
      case (opcode_i)
        ibsd_pkg::OP_BYTE: begin
          unique case (phase_q)
            ibsd_pkg::PH_PREFIX: begin
              prefix_count_d = prefix_count_q + 2'd1;
              if (prefix_count_q == 2'd3) begin
                phase_d = ibsd_pkg::PH_HEADER;
              end
            end
            ibsd_pkg::PH_HEADER: begin
              if (header_count_q[3:2] == 2'b00 &&
                  rx_byte_i != ibsd_pkg::magic_byte(header_count_q[1:0])) begin
                magic_ok_d = 1'b0;
              end
              if (header_count_q[3:2] == 2'b01) begin
                length_word_d = {length_word_q[23:0], rx_byte_i};
              end
              header_count_d = header_count_q + 4'd1;
              if (header_count_q == 4'(ibsd_pkg::HDR_BYTES - 1)) begin
                push_o = 1'b1;
                if (hdr_ok) begin
                  push_cmd_o.op = ibsd_pkg::CMD_HDR_ACK;
                  phase_d = ibsd_pkg::PH_MARKER;
                end else begin
                  push_cmd_o.op = ibsd_pkg::CMD_ERR;
                  push_cmd_o.data = ibsd_pkg::ERR_BAD_HEADER;
                  phase_d = ibsd_pkg::PH_ERROR;
                end
              end
            end
            ibsd_pkg::PH_MARKER: begin
              push_o = 1'b1;
              if (rx_byte_i == ibsd_pkg::MARK_STOP) begin
                // acknowledge and restart the session
                push_cmd_o.op = ibsd_pkg::CMD_ACK;
                phase_d = ibsd_pkg::PH_PREFIX;
                prefix_count_d = '0;
                header_count_d = '0;
                magic_ok_d = 1'b1;
                length_word_d = '0;
                payload_count_d = '0;
              end else if (rx_byte_i == ibsd_pkg::MARK_IMAGE) begin
                push_o = 1'b0;
                payload_count_d = '0;
                phase_d = ibsd_pkg::PH_PAYLOAD;
              end else begin
                push_cmd_o.op = ibsd_pkg::CMD_ERR;
                push_cmd_o.data = ibsd_pkg::ERR_BAD_MARKER;
                phase_d = ibsd_pkg::PH_ERROR;
              end
            end
            ibsd_pkg::PH_PAYLOAD: begin
              push_o = 1'b1;
              push_cmd_o.addr = 16'(payload_count_q);
              push_cmd_o.data = rx_byte_i;
              if (LW'(count_next) >= limit) begin
                push_cmd_o.op = ibsd_pkg::CMD_STORE_LAST;
                payload_count_d = '0;
                phase_d = ibsd_pkg::PH_ACCEL;
              end else begin
                payload_count_d = count_next;
              end
            end
            default: begin
              // drop bytes while busy or locked in error
            end
          endcase
        end
        ibsd_pkg::OP_ACCEL_DONE: begin
          if (phase_q == ibsd_pkg::PH_ACCEL) begin
            push_o = 1'b1;
            push_cmd_o.op = ibsd_pkg::CMD_XFER;
            phase_d = ibsd_pkg::PH_XFER;
          end
        end
        ibsd_pkg::OP_XFER_DONE: begin
          if (phase_q == ibsd_pkg::PH_XFER) begin
            push_o = 1'b1;
            push_cmd_o.op = ibsd_pkg::CMD_ACK;
            phase_d = ibsd_pkg::PH_MARKER;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ibsd_pkg::PH_PREFIX;
      prefix_count_q <= '0;
      header_count_q <= '0;
      magic_ok_q <= 1'b1;
      length_word_q <= '0;
      payload_count_q <= '0;
    end else begin
      phase_q <= phase_d;
      prefix_count_q <= prefix_count_d;
      header_count_q <= header_count_d;
      magic_ok_q <= magic_ok_d;
      length_word_q <= length_word_d;
      payload_count_q <= payload_count_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ibsd_queue.sv -----
`default_nettype none
module ibsd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ibsd_pkg::cmd_t push_cmd_i,
  input  wire logic           pop_i,
  output ibsd_pkg::cmd_t      head_o,
  output logic                head_valid_o,
  output logic                full_o
);

  localparam int unsigned PW = $clog2(ibsd_pkg::QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(ibsd_pkg::QUEUE_DEPTH + 1);

  ibsd_pkg::cmd_t entry_q [ibsd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] count_q, count_d;

  assign head_o = entry_q[rd_ptr_q];
  assign head_valid_o = (count_q != '0);
  assign full_o = (count_q == NW'(ibsd_pkg::QUEUE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + NW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ibsd_back.sv -----
`default_nettype none
module ibsd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ibsd_pkg::cmd_t head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  input  wire logic [31:0]    out_bytes_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [2:0]          kind_o,
  output logic [15:0]         byte_address_o,
  output logic [7:0]          data_byte_o,
  output logic                last_o
);

  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  ibsd_pkg::kind_e kind_q, kind_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        last_q, last_d;
  logic        load, at_end;

  assign load = head_valid_i && (!out_valid_q || !out_stall_i);
  assign at_end = (idx_q == ibsd_pkg::cmd_last_idx(head_i.op));
  assign pop_o = load && at_end;

  always_comb begin
    kind_d = ibsd_pkg::KIND_RESP;
    addr_d = '0;
    data_d = '0;
    last_d = at_end;
    unique case (head_i.op)
      ibsd_pkg::CMD_STORE: begin
        kind_d = ibsd_pkg::KIND_STORE;
        addr_d = head_i.addr;
        data_d = head_i.data;
      end
      ibsd_pkg::CMD_STORE_LAST: begin
        if (idx_q == 3'd0) begin
          kind_d = ibsd_pkg::KIND_STORE;
          addr_d = head_i.addr;
          data_d = head_i.data;
        end else begin
          kind_d = ibsd_pkg::KIND_START_ACCEL;
        end
      end
      ibsd_pkg::CMD_HDR_ACK: begin
        case (idx_q)
          3'd0, 3'd1, 3'd2: data_d = ibsd_pkg::ack_byte(idx_q[1:0]);
          3'd3: data_d = out_bytes_i[31:24];
          3'd4: data_d = out_bytes_i[23:16];
          3'd5: data_d = out_bytes_i[15:8];
          default: data_d = out_bytes_i[7:0];
        endcase
      end
      ibsd_pkg::CMD_ACK: data_d = ibsd_pkg::ack_byte(idx_q[1:0]);
      ibsd_pkg::CMD_ERR: begin
        kind_d = ibsd_pkg::KIND_ERROR;
        data_d = head_i.data;
      end
      default: kind_d = ibsd_pkg::KIND_START_XFER;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign byte_address_o = addr_q;
  assign data_byte_o = data_q;
  assign last_o = last_q;

endmodule
`default_nettype wire

// ----- sv/image_batch_session_deframer.sv -----
// Image-batch session deframer.
// Input channel: in_valid_i / in_stall_o carry one transaction per cycle, an
// opcode (received byte, accelerator done, transfer done) and the byte.
// Output channel: out_valid_o / out_stall_i carry result transactions (kind,
// store address, data byte, last), one per cycle.
// Each input transaction is classified in the cycle it is taken and leaves at
// most one burst command in a four-entry queue; a sequencer expands the
// command into 1, 2, 3 or 7 results. The command waits in a queue entry and
// each result is held in the sequencer's output register. Payload bytes run
// at one transaction per cycle unless stalled; the last payload byte and
// acknowledgements become 2, 3 or 7 results, issued one per unstalled cycle.
// in_stall_o rises only when the queue is full, so a stalled receiver backs
// up through the queue into the input; nothing is lost or repeated.
// Reset clears the session to wait for the length prefix and loads the
// registers with their defaults (4096 input bytes, 24576 output bytes).
// Write cfg_index_i 0 / 1 only while no transaction is in flight.
`default_nettype none
module image_batch_session_deframer #(
  parameter int unsigned MAX_PAYLOAD_BYTES = ibsd_pkg::MAX_PAYLOAD_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [15:0]      byte_address_o,
  output logic [7:0]       data_byte_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [16:0] in_bytes_q;
  logic [31:0] out_bytes_q;
  logic        accept, push, pop, head_valid, full;
  ibsd_pkg::cmd_t push_cmd, head;

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bytes_q <= ibsd_pkg::IN_BYTES_RST;
      out_bytes_q <= ibsd_pkg::OUT_BYTES_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ibsd_pkg::CFG_IN_BYTES) begin
        in_bytes_q <= cfg_data_i[16:0];
      end else begin
        out_bytes_q <= cfg_data_i;
      end
    end
  end

  ibsd_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .rx_byte_i  (rx_byte_i),
    .in_bytes_i (in_bytes_q),
    .push_cmd_o (push_cmd),
    .push_o     (push)
  );

  ibsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .full_o       (full)
  );

  ibsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .out_bytes_i    (out_bytes_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire

// ----- sv/ibsd_checker.sv -----
`default_nettype none
`include "image_batch_session_deframer_assert.svh"
module ibsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  opcode_i,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  kind_o,
  input wire logic [15:0] byte_address_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic        last_o
);

  logic [2:0] k_store, k_accel, k_xfer, k_err;

  assign k_store = ibsd_pkg::KIND_STORE;
  assign k_accel = ibsd_pkg::KIND_START_ACCEL;
  assign k_xfer = ibsd_pkg::KIND_START_XFER;
  assign k_err = ibsd_pkg::KIND_ERROR;

  // hold a stalled input transaction
  `IBSD_ASSERT_IMP(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o,
    ##1 (in_valid_i && $stable({opcode_i, rx_byte_i})), "stalled input changed")

  // hold a stalled result transaction
  `IBSD_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    ##1 (out_valid_o && $stable({kind_o, byte_address_o, data_byte_o, last_o})),
    "stalled result changed")

  // start, transfer and error results always close their burst
  `IBSD_ASSERT_IMP(a_single_last, clk_i, rst_ni,
    out_valid_o && (kind_o == k_accel || kind_o == k_xfer || kind_o == k_err),
    last_o, "command or error result not marked last")

  // only stored payload bytes carry an address
  `IBSD_ASSERT_IMP(a_addr_zero, clk_i, rst_ni, out_valid_o && kind_o != k_store,
    byte_address_o == 16'd0, "non-payload result has an address")

  // start accelerator follows directly on the final payload byte
  `IBSD_ASSERT_IMP(a_accel_after_store, clk_i, rst_ni,
    out_valid_o && !out_stall_i && kind_o == k_store && !last_o,
    ##1 (out_valid_o && kind_o == k_accel), "final payload byte not followed by start")

endmodule

bind image_batch_session_deframer ibsd_checker u_ibsd_checker (.*);
`default_nettype wire
